FILE: rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffba_pkg
// shared constants, codes and types of the first-fit block allocator
// ---------------------------------------------------------------------------
package ffba_pkg;

   localparam int HEAP_BYTES   = 1024;
   localparam int HEADER_BYTES = 16;
   localparam int GRAN_BYTES   = 8;
   localparam int NGRAN        = HEAP_BYTES / GRAN_BYTES;
   localparam int GRAN_W       = $clog2(NGRAN);
   localparam int LINK_W       = GRAN_W + 1;
   localparam int MODE_W       = 2;
   localparam int REQ_W        = 11;
   localparam int OFF_W        = 10;
   localparam int SIZE_W       = 11;
   localparam int CALC_W       = 12;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(NGRAN);

   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_ALLOC = 2'd0;
   localparam mode_type MODE_FREE  = 2'd1;
   localparam mode_type MODE_INIT  = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_WRITE1,
      ST_WRITE2,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/ffba_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if
// valid/ready channels for requests and results of the allocator
// ---------------------------------------------------------------------------
interface ffba_req_if;
   logic                             valid;
   logic                             ready;
   logic [ffba_pkg::MODE_W-1:0]      mode;
   logic [ffba_pkg::REQ_W-1:0]       request_size;
   logic [ffba_pkg::OFF_W-1:0]       block_offset;
   modport source (output valid, mode, request_size, block_offset, input ready);
   modport sink   (input valid, mode, request_size, block_offset, output ready);
endinterface

interface ffba_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ffba_pkg::OFF_W-1:0]       payload_offset;
   logic                             granted;
   modport source (output valid, payload_offset, granted, input ready);
   modport sink   (input valid, payload_offset, granted, output ready);
endinterface

FILE: rtl/core/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator over an address-ordered free list held in block ram
// ---------------------------------------------------------------------------
// One word is taken at a time. Allocate and free walk the free list one
// block per cycle through the header memories, whose reads are registered:
// fetch, a check per visited free block and, on success, write1 and where
// needed write2, bounded by the walk limit of 128 links. Reinitialize
// passes through the init state and a free at the list head through write1
// alone; a word that needs no walk (null, malformed or head double free,
// undefined mode, allocate on an empty list) goes from idle straight to
// done. A finished word holds for as long as the output register is still
// full, and the input stalls meanwhile. After reset the block sets up the
// initial free block before it takes a word. The result sits in an output
// register, and the next word may be taken while it waits.
module first_fit_block_allocator (
   input  logic           clock,
   input  logic           reset,
   ffba_req_if.sink       req_ch,
   ffba_rsp_if.source     rsp_ch
);

   localparam int GW = ffba_pkg::GRAN_W;
   localparam int LW = ffba_pkg::LINK_W;
   localparam int CW = ffba_pkg::CALC_W;
   localparam int SW = ffba_pkg::SIZE_W;
   localparam int OW = ffba_pkg::OFF_W;

   // header memories
   logic [SW-1:0] size_mem [ffba_pkg::NGRAN];
   logic [LW-1:0] next_mem [ffba_pkg::NGRAN];

   ffba_pkg::state_type state_ff, state_in;
   ffba_pkg::mode_type  op_ff;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] cur_ff, prev_ff, nlink_ff;
   logic [LW-1:0] steps_ff;
   logic [CW-1:0] size_ff;
   logic [GW-1:0] blk_ff, split_ff;
   logic [SW-1:0] rem_ff;
   logic          split_ok_ff, head_ins_ff, ok_ff;
   logic          rsp_valid_ff;
   logic [OW-1:0] rsp_off_ff;
   logic          rsp_ok_ff;

   logic [SW-1:0] rd_size_ff;
   logic [LW-1:0] rd_next_ff;
   logic [GW-1:0] rd_addr;

   logic          size_we, next_we;
   logic [GW-1:0] size_wa, next_wa;
   logic [SW-1:0] size_wd;
   logic [LW-1:0] next_wd;

   logic          accept;
   logic [LW-1:0] link;
   logic [CW-1:0] total, rd_size_x;
   logic          fits, can_split;
   logic [LW+2:0] split_at;
   logic          steps_over;
   logic [CW-1:0] req_round;
   logic [OW-1:0] off_m;
   logic          free_null, free_bad;
   logic [GW-1:0] free_blk;
   logic          out_free;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign link      = (rd_next_ff > ffba_pkg::NIL) ? ffba_pkg::NIL : rd_next_ff;
   assign total     = size_ff + CW'(ffba_pkg::HEADER_BYTES);
   assign rd_size_x = CW'(rd_size_ff);
   assign fits      = rd_size_x >= total;
   assign split_at  = (LW+3)'(cur_ff) + (LW+3)'(total[CW-1:3]);
   assign can_split = (rd_size_x >= total + CW'(ffba_pkg::HEADER_BYTES + ffba_pkg::GRAN_BYTES))
                      && (split_at < (LW+3)'(ffba_pkg::NGRAN));
   assign steps_over = steps_ff >= LW'(ffba_pkg::NGRAN);

   assign req_round = (CW'(req_ch.request_size) + CW'(ffba_pkg::GRAN_BYTES - 1))
                      & ~CW'(ffba_pkg::GRAN_BYTES - 1);
   assign off_m     = req_ch.block_offset - OW'(ffba_pkg::HEADER_BYTES);
   assign free_null = req_ch.block_offset == '0;
   assign free_bad  = (req_ch.block_offset < OW'(ffba_pkg::HEADER_BYTES))
                      || (off_m[2:0] != 3'd0);
   assign free_blk  = off_m[GW+2:3];

   assign req_ch.ready         = state_ff == ffba_pkg::ST_IDLE;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.payload_offset = rsp_off_ff;
   assign rsp_ch.granted        = rsp_ok_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffba_pkg::ST_INIT:
            state_in = (op_ff == ffba_pkg::MODE_INIT) ? ffba_pkg::ST_DONE : ffba_pkg::ST_IDLE;
         ffba_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (req_ch.mode == ffba_pkg::MODE_INIT) state_in = ffba_pkg::ST_INIT;
               else if (req_ch.mode == ffba_pkg::MODE_ALLOC)
                  state_in = (head_ff == ffba_pkg::NIL) ? ffba_pkg::ST_DONE : ffba_pkg::ST_FETCH;
               else if (req_ch.mode == ffba_pkg::MODE_FREE) begin
                  priority if (free_null || free_bad) state_in = ffba_pkg::ST_DONE;
                  else if (head_ff == ffba_pkg::NIL || LW'(free_blk) < head_ff)
                     state_in = ffba_pkg::ST_WRITE1;
                  else if (LW'(free_blk) == head_ff) state_in = ffba_pkg::ST_DONE;
                  else state_in = ffba_pkg::ST_FETCH;
               end
               else state_in = ffba_pkg::ST_DONE;
            end
         end
         ffba_pkg::ST_FETCH: state_in = ffba_pkg::ST_CHECK;
         ffba_pkg::ST_CHECK: begin
            if (op_ff == ffba_pkg::MODE_ALLOC) begin
               priority if (fits) state_in = ffba_pkg::ST_WRITE1;
               else if (steps_over || link == ffba_pkg::NIL) state_in = ffba_pkg::ST_DONE;
               else state_in = ffba_pkg::ST_CHECK;
            end else begin
               priority if (link != ffba_pkg::NIL && link < LW'(blk_ff)) begin
                  if (steps_over) state_in = ffba_pkg::ST_DONE;
               end
               else if (link == LW'(blk_ff)) state_in = ffba_pkg::ST_DONE;
               else state_in = ffba_pkg::ST_WRITE1;
            end
         end
         ffba_pkg::ST_WRITE1: begin
            if (op_ff == ffba_pkg::MODE_ALLOC)
               state_in = split_ok_ff ? ffba_pkg::ST_WRITE2 : ffba_pkg::ST_DONE;
            else
               state_in = head_ins_ff ? ffba_pkg::ST_DONE : ffba_pkg::ST_WRITE2;
         end
         ffba_pkg::ST_WRITE2: state_in = ffba_pkg::ST_DONE;
         ffba_pkg::ST_DONE:   if (out_free) state_in = ffba_pkg::ST_IDLE;
         default:             state_in = ffba_pkg::ST_IDLE;
      endcase
   end

   // memory ports and head pointer
   always_comb begin
      size_we = 1'b0;
      size_wa = '0;
      size_wd = '0;
      next_we = 1'b0;
      next_wa = '0;
      next_wd = '0;
      head_in = head_ff;
      rd_addr = cur_ff[GW-1:0];
      unique case (state_ff)
         ffba_pkg::ST_INIT: begin
            size_we = 1'b1;
            size_wd = SW'(ffba_pkg::HEAP_BYTES - ffba_pkg::HEADER_BYTES);
            next_we = 1'b1;
            next_wd = ffba_pkg::NIL;
            head_in = '0;
         end
         ffba_pkg::ST_CHECK: rd_addr = link[GW-1:0];
         ffba_pkg::ST_WRITE1: begin
            if (op_ff == ffba_pkg::MODE_ALLOC) begin
               size_we = 1'b1;
               if (split_ok_ff) begin
                  size_wa = split_ff;
                  size_wd = rem_ff;
                  next_we = 1'b1;
                  next_wa = split_ff;
                  next_wd = nlink_ff;
                  if (prev_ff == ffba_pkg::NIL) head_in = LW'(split_ff);
               end else begin
                  size_wa = cur_ff[GW-1:0];
                  size_wd = size_ff[SW-1:0];
                  if (prev_ff == ffba_pkg::NIL) head_in = nlink_ff;
                  else begin
                     next_we = 1'b1;
                     next_wa = prev_ff[GW-1:0];
                     next_wd = nlink_ff;
                  end
               end
            end else begin
               next_we = 1'b1;
               next_wa = blk_ff;
               next_wd = nlink_ff;
               if (head_ins_ff) head_in = LW'(blk_ff);
            end
         end
         ffba_pkg::ST_WRITE2: begin
            if (op_ff == ffba_pkg::MODE_ALLOC) begin
               size_we = 1'b1;
               size_wa = cur_ff[GW-1:0];
               size_wd = size_ff[SW-1:0];
               if (prev_ff != ffba_pkg::NIL) begin
                  next_we = 1'b1;
                  next_wa = prev_ff[GW-1:0];
                  next_wd = LW'(split_ff);
               end
            end else begin
               next_we = 1'b1;
               next_wa = cur_ff[GW-1:0];
               next_wd = LW'(blk_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_wa] <= size_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      rd_size_ff <= size_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::ST_INIT;
         op_ff        <= ffba_pkg::MODE_ALLOC;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= (state_ff == ffba_pkg::ST_DONE && out_free)
                         || (rsp_valid_ff && !rsp_ch.ready);
         if (state_ff == ffba_pkg::ST_DONE && out_free) begin
            rsp_ok_ff    <= ok_ff;
            rsp_off_ff   <= (ok_ff && op_ff == ffba_pkg::MODE_ALLOC)
                            ? OW'({cur_ff[GW-1:0], 3'b000} + (GW+3)'(ffba_pkg::HEADER_BYTES))
                            : '0;
         end
         if (accept) op_ff <= req_ch.mode;
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ffba_pkg::ST_INIT: ok_ff <= 1'b1;
         ffba_pkg::ST_IDLE: begin
            size_ff     <= req_round;
            blk_ff      <= free_blk;
            cur_ff      <= head_ff;
            prev_ff     <= ffba_pkg::NIL;
            steps_ff    <= '0;
            nlink_ff    <= head_ff;
            head_ins_ff <= head_ff == ffba_pkg::NIL || LW'(free_blk) < head_ff;
            ok_ff       <= (req_ch.mode == ffba_pkg::MODE_FREE) && free_null;
         end
         ffba_pkg::ST_CHECK: begin
            if (op_ff == ffba_pkg::MODE_ALLOC) begin
               if (fits) begin
                  split_ok_ff <= can_split;
                  split_ff    <= split_at[GW-1:0];
                  rem_ff      <= rd_size_ff - total[SW-1:0];
                  nlink_ff    <= link;
               end else begin
                  steps_ff <= steps_ff + 1'b1;
                  prev_ff  <= cur_ff;
                  cur_ff   <= link;
               end
            end else begin
               if (link != ffba_pkg::NIL && link < LW'(blk_ff)) begin
                  steps_ff <= steps_ff + 1'b1;
                  cur_ff   <= link;
               end else nlink_ff <= link;
            end
         end
         ffba_pkg::ST_WRITE1: ok_ff <= 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks first_fit_block_allocator against a behavioral free-list predictor
// ---------------------------------------------------------------------------
// Directed words cover allocate, free and reinitialize at the field limits,
// together with null, malformed and double frees and the undefined mode.
// Random words then run mostly well-formed allocate/free traffic under
// three idling profiles. A long receiver hold-off fills the block up. Every
// result is compared in order with the prediction.
module testbench;
   import ffba_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;

   typedef struct {
      logic [OFF_W-1:0] payload_offset;
      logic             granted;
   } grant_type;

   logic clock;
   logic reset;

   ffba_req_if req_if ();
   ffba_rsp_if rsp_if ();

   first_fit_block_allocator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // predictor state
   int        heap_head;
   int        hdr_size [NGRAN];
   int        hdr_next [NGRAN];
   int        live_offsets [$];
   grant_type expected_grants [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int mismatches;
   int idle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void heap_reinit();
      for (int g = 0; g < NGRAN; g++) begin
         hdr_size[g] = 0;
         hdr_next[g] = 0;
      end
      hdr_size[0] = HEAP_BYTES - HEADER_BYTES;
      hdr_next[0] = NGRAN;
      heap_head   = 0;
      live_offsets.delete();
   endfunction

   function automatic int next_free(int g);
      return (hdr_next[g] > NGRAN) ? NGRAN : hdr_next[g];
   endfunction

   function automatic void relink(int prev, int val);
      if (prev == NGRAN) begin
         heap_head = val;
      end else begin
         hdr_next[prev] = val;
      end
   endfunction

   function automatic int first_fit(int request, output int offset);
      int size;
      int total;
      int cur;
      int prev;
      int steps;
      int split_at;
      size  = (request + 7) & ~7;
      total = size + HEADER_BYTES;
      cur   = heap_head;
      prev  = NGRAN;
      steps = 0;
      offset = 0;
      while (cur != NGRAN && hdr_size[cur] < total) begin
         steps++;
         if (steps > NGRAN) return 0;
         prev = cur;
         cur  = next_free(cur);
      end
      if (cur == NGRAN) return 0;
      split_at = cur + total / GRAN_BYTES;
      if (hdr_size[cur] >= total + HEADER_BYTES + 8 && split_at < NGRAN) begin
         hdr_size[split_at] = hdr_size[cur] - total;
         hdr_next[split_at] = next_free(cur);
         relink(prev, split_at);
      end else begin
         relink(prev, next_free(cur));
      end
      hdr_size[cur] = size;
      offset = cur * GRAN_BYTES + HEADER_BYTES;
      return 1;
   endfunction

   function automatic int release_block(int offset);
      int blk;
      int cur;
      int nxt;
      int steps;
      if (offset == 0) return 1;
      if (offset < HEADER_BYTES || ((offset - HEADER_BYTES) & 7) != 0) return 0;
      blk = (offset - HEADER_BYTES) / GRAN_BYTES;
      if (blk >= NGRAN) return 0;
      if (heap_head == NGRAN || blk < heap_head) begin
         hdr_next[blk] = heap_head;
         heap_head = blk;
         return 1;
      end
      if (blk == heap_head) return 0;
      cur   = heap_head;
      steps = 0;
      nxt   = next_free(cur);
      while (nxt != NGRAN && nxt < blk) begin
         steps++;
         if (steps > NGRAN) return 0;
         cur = nxt;
         nxt = next_free(cur);
      end
      if (nxt == blk) return 0;
      hdr_next[blk] = nxt;
      hdr_next[cur] = blk;
      return 1;
   endfunction

   function automatic grant_type predict_grant(mode_type mode, int request, int offset);
      grant_type g;
      int        off;
      int        ok;
      off = 0;
      ok  = 0;
      if (mode == MODE_ALLOC) begin
         ok = first_fit(request, off);
         if (ok != 0) live_offsets.push_back(off);
      end else if (mode == MODE_FREE) begin
         ok = release_block(offset);
         if (ok != 0 && offset != 0) begin
            foreach (live_offsets[i]) begin
               if (live_offsets[i] == offset) begin
                  live_offsets.delete(i);
                  break;
               end
            end
         end
      end else if (mode == MODE_INIT) begin
         heap_reinit();
         ok = 1;
      end
      g.payload_offset = OFF_W'(off);
      g.granted        = (ok != 0);
      return g;
   endfunction

   task automatic send_word(mode_type mode, int request, int offset);
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.mode         <= mode;
      req_if.request_size <= REQ_W'(request);
      req_if.block_offset <= OFF_W'(offset);
      do @(posedge clock); while (!req_if.ready);
      expected_grants.push_back(predict_grant(mode, request, offset));
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
   endtask

   // current member of the free list, for double frees
   function automatic int free_list_offset();
      int cur;
      int pick;
      cur  = heap_head;
      pick = $urandom_range(7);
      if (cur == NGRAN) return 0;
      while (pick > 0 && next_free(cur) != NGRAN) begin
         cur = next_free(cur);
         pick--;
      end
      return cur * GRAN_BYTES + HEADER_BYTES;
   endfunction

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles  <= hold_cycles - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %0d/%0b",
               rsp_if.payload_offset, rsp_if.granted);
         end else begin
            if (rsp_if.payload_offset !== expected_grants[0].payload_offset ||
                rsp_if.granted !== expected_grants[0].granted) begin
               mismatches++;
               if (mismatches <= 10) $display(
                  "mismatch: offset exp %0d got %0d, granted exp %0b got %0b",
                  expected_grants[0].payload_offset, rsp_if.payload_offset,
                  expected_grants[0].granted, rsp_if.granted);
            end
            void'(expected_grants.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic test_alloc_limits();
      send_word(MODE_ALLOC, 0, 0);
      send_word(MODE_ALLOC, 1, 0);
      send_word(MODE_ALLOC, 1024, 0);
      send_word(MODE_ALLOC, 2047, 0);
      send_word(MODE_ALLOC, 9, 0);
      send_word(MODE_INIT, 0, 0);
      // request plus header is the whole heap minus header, no split possible
      send_word(MODE_ALLOC, HEAP_BYTES - 2 * HEADER_BYTES, 0);
      send_word(MODE_ALLOC, 0, 0);
      send_word(MODE_INIT, 0, 0);
      // remainder large enough for a header and a granule, block is split
      send_word(MODE_ALLOC, HEAP_BYTES - 4 * HEADER_BYTES, 0);
      send_word(MODE_INIT, 0, 0);
   endtask

   task automatic test_free_cases();
      send_word(MODE_ALLOC, 40, 0);
      send_word(MODE_ALLOC, 8, 0);
      send_word(MODE_ALLOC, 100, 0);
      send_word(MODE_FREE, 0, 16);
      send_word(MODE_FREE, 0, 16);
      send_word(MODE_FREE, 0, 0);
      send_word(MODE_FREE, 0, 8);
      send_word(MODE_FREE, 0, 17);
      send_word(MODE_FREE, 0, 1023);
      send_word(MODE_FREE, 2047, free_list_offset());
      send_word(mode_type'(2'd3), 2047, 1023);
      send_word(MODE_ALLOC, 40, 0);
      send_word(MODE_INIT, 0, 0);
   endtask

   task automatic random_word();
      int r;
      int off;
      r = $urandom_range(999);
      if (r < 8) begin
         send_word(MODE_INIT, $urandom_range(2047), $urandom_range(1023));
      end else if (r < 14) begin
         send_word(mode_type'(2'd3), $urandom_range(2047), $urandom_range(1023));
      end else if (r < 40) begin
         send_word(MODE_FREE, $urandom_range(2047), $urandom_range(15));
      end else if (r < 60) begin
         send_word(MODE_FREE, 0, free_list_offset());
      end else if (r < 500 && live_offsets.size() > 0) begin
         off = live_offsets[$urandom_range(live_offsets.size() - 1)];
         send_word(MODE_FREE, $urandom_range(2047), off);
      end else begin
         if ($urandom_range(19) == 0) begin
            off = $urandom_range(2047);
         end else begin
            off = $urandom_range(120);
         end
         send_word(MODE_ALLOC, off, $urandom_range(1023));
      end
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) random_word();
   endtask

   task automatic test_output_stall();
      send_idle_pct = 0;
      hold_cycles   = 400;
      repeat (20) random_word();
   endtask

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.mode         = MODE_ALLOC;
      req_if.request_size = '0;
      req_if.block_offset = '0;
      rsp_if.ready        = 1'b0;
      send_idle_pct       = 32;
      recv_idle_pct       = 67;
      hold_cycles         = 0;
      mismatches          = 0;
      idle_count          = 0;
      heap_reinit();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_alloc_limits();
      test_free_cases();
      test_random_traffic(500);
      send_idle_pct = 67;
      recv_idle_pct = 32;
      test_random_traffic(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(500);
      test_output_stall();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_grants.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_grants.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_if.sv
rtl/core/first_fit_block_allocator.sv
bench/testbench.sv
